// ===== design/cfvg_pkg.sv =====
`default_nettype none
package cfvg_pkg;

  localparam int MAX_VERTICES  = 1024;
  localparam int CORDIC_STAGES = 16;
  localparam int FRAC_BITS     = 8;

  localparam int IDX_W      = 10;
  localparam int CNT_W      = 11;
  localparam int RAD_W      = 10;
  localparam int POS_W      = 19;
  localparam int PH_W       = 16;
  localparam int DIV_STAGES = PH_W;
  localparam int LIM_W      = RAD_W + FRAC_BITS;
  localparam int GAIN_W     = 32;
  localparam int PROD_W     = LIM_W + GAIN_W;
  localparam int GUARD      = 16;
  localparam int XW         = 38;
  localparam int ZW         = 32;
  localparam int RW         = XW - GUARD;
  localparam int OUT_MAX    = 262143;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS       = 2'd1;

  localparam logic [CNT_W-1:0] VERTEX_COUNT_RST = 11'd100;
  localparam logic [RAD_W-1:0] RADIUS_RST       = 10'd3;

  localparam logic [GAIN_W-1:0] GAIN_Q32 = 32'd2608131496;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [ZW-1:0] ATAN_TURNS [0:23] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
    32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
    32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  typedef struct packed {
    logic [PH_W-1:0] phase;
    logic            rim;
    logic            in_range;
    logic            odd;
  } qitem_t;

endpackage
`default_nettype wire

// ===== design/circle_fan_vertex_generator.sv =====
// Circle fan vertex generator.
// Input channel: in_valid/in_ready carry a vertex index; index 0 is the
// fan center, indices 1 to count-1 lie on the rim, higher ones are out of
// range and come back as zeros with out_in_range low.
// Result channel: out_valid/out_ready carry x and y in 1/256 units, the
// color bits and out_in_range, exactly one beat per input beat, in order.
// Configuration: cfg_valid/cfg_ready write vertex_count (index 0) or
// radius (index 1); cfg_ready is always high. Write only while idle.
// Throughput: one index per cycle while in_ready is high. Path from the input
// beat to the result beat: pipelined phase division, the queue, a multiply
// stage, 17 CORDIC stages and two output stages.
// A four-entry queue sits between the divider and the CORDIC pipeline.
// When the receiver stalls, the CORDIC pipeline holds, the queue fills and
// only then in_ready drops.
// Reset clears the pipelines and sets vertex_count to 100, radius to 3.
`default_nettype none
module circle_fan_vertex_generator (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [cfvg_pkg::IDX_W-1:0]       in_vertex_index,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [cfvg_pkg::POS_W-1:0]            out_x_pos,
  output logic [cfvg_pkg::POS_W-1:0]            out_y_pos,
  output logic                                  out_color_red,
  output logic                                  out_color_green,
  output logic                                  out_color_blue,
  output logic                                  out_in_range,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [cfvg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [cfvg_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import cfvg_pkg::*;

  logic [CNT_W-1:0] vertex_count_r;
  logic [RAD_W-1:0] radius_r;
  qitem_t           push_item;
  qitem_t           pop_item;
  logic             q_push;
  logic             q_full;
  logic             q_pop;
  logic             q_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_count_r <= VERTEX_COUNT_RST;
      radius_r       <= RADIUS_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_VERTEX_COUNT: vertex_count_r <= CNT_W'(cfg_data);
        REG_RADIUS:       radius_r       <= RAD_W'(cfg_data);
        default: ;
      endcase
    end
  end

  cfvg_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_vertex_index (in_vertex_index),
    .vertex_count    (vertex_count_r),
    .q_push          (q_push),
    .q_item          (push_item),
    .q_full          (q_full)
  );

  cfvg_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .empty     (q_empty)
  );

  cfvg_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_item          (pop_item),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .radius          (radius_r),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_x_pos       (out_x_pos),
    .out_y_pos       (out_y_pos),
    .out_color_red   (out_color_red),
    .out_color_green (out_color_green),
    .out_color_blue  (out_color_blue),
    .out_in_range    (out_in_range)
  );

`ifndef SYNTHESIS
  a_out_of_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_in_range |-> out_x_pos == '0 && out_y_pos == '0 &&
      !out_color_red && !out_color_green && !out_color_blue)
    else $error("out-of-range beat carries nonzero payload");

  a_color_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_in_range |->
      out_color_red != out_color_green && out_color_red == out_color_blue)
    else $error("color is neither magenta nor green");

  a_x_in_radius: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_in_range |->
      $signed(out_x_pos) <= $signed({1'b0, radius_r, 8'h00}) &&
      $signed(out_x_pos) >= -$signed({1'b0, radius_r, 8'h00}))
    else $error("x coordinate outside the radius");

  a_y_in_radius: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_in_range |->
      $signed(out_y_pos) <= $signed({1'b0, radius_r, 8'h00}) &&
      $signed(out_y_pos) >= -$signed({1'b0, radius_r, 8'h00}))
    else $error("y coordinate outside the radius");
`endif

endmodule
`default_nettype wire

// ===== design/cfvg_front.sv =====
`default_nettype none
module cfvg_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [cfvg_pkg::IDX_W-1:0]  in_vertex_index,
  input  wire logic [cfvg_pkg::CNT_W-1:0]  vertex_count,
  output logic                             q_push,
  output cfvg_pkg::qitem_t                 q_item,
  input  wire logic                        q_full
);
  import cfvg_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0] rem;
    logic [IDX_W-1:0] dsr;
    logic [PH_W-1:0]  quo;
    logic             rim;
    logic             in_range;
    logic             odd;
  } dstage_t;

  dstage_t          st_r [0:DIV_STAGES];
  logic [DIV_STAGES:0] vld_r;
  dstage_t          st0;
  logic             en;
  logic [CNT_W-1:0] count_c;
  logic [IDX_W-1:0] m;
  logic [IDX_W-1:0] d;
  logic             wrap;

  // One quotient bit per stage of restoring division.
  function automatic dstage_t div_step(input dstage_t s);
    logic [IDX_W:0] r2;
    logic           ge;
    dstage_t        o;
    r2 = {s.rem, 1'b0};
    ge = (r2 >= {1'b0, s.dsr});
    o = s;
    o.rem = ge ? IDX_W'(r2 - {1'b0, s.dsr}) : IDX_W'(r2);
    o.quo = {s.quo[PH_W-2:0], ge};
    return o;
  endfunction

  assign en       = !(vld_r[DIV_STAGES] && q_full);
  assign in_ready = en;
  assign q_push   = vld_r[DIV_STAGES] && !q_full;

  assign q_item.phase    = st_r[DIV_STAGES].quo;
  assign q_item.rim      = st_r[DIV_STAGES].rim;
  assign q_item.in_range = st_r[DIV_STAGES].in_range;
  assign q_item.odd      = st_r[DIV_STAGES].odd;

  always_comb begin
    count_c = (vertex_count > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : vertex_count;
    m = in_vertex_index - IDX_W'(1);
    d = IDX_W'(count_c - CNT_W'(2));
    // The closing rim point wraps to phase zero, as does every rim point
    // of a fan with at most two vertices.
    wrap = (count_c <= CNT_W'(2)) || (m == d);
    st0.rem      = wrap ? '0 : m;
    st0.dsr      = wrap ? IDX_W'(1) : d;
    st0.quo      = '0;
    st0.rim      = (in_vertex_index != '0);
    st0.in_range = ({1'b0, in_vertex_index} < count_c);
    st0.odd      = in_vertex_index[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DIV_STAGES-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0] <= st0;
      for (int i = 0; i < DIV_STAGES; i++) begin
        st_r[i+1] <= div_step(st_r[i]);
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/cfvg_queue.sv =====
`default_nettype none
module cfvg_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  cfvg_pkg::qitem_t       push_item,
  output logic                   full,
  input  wire logic              pop,
  output cfvg_pkg::qitem_t       pop_item,
  output logic                   empty
);
  import cfvg_pkg::*;

  qitem_t          mem [0:Q_DEPTH-1];
  logic [Q_AW-1:0] wr_ptr_r;
  logic [Q_AW-1:0] rd_ptr_r;
  logic [Q_AW:0]   cnt_r;
  logic            do_push;
  logic            do_pop;

  assign full     = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_item = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + Q_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + Q_AW'(1);
      end
      cnt_r <= cnt_r + (Q_AW+1)'(do_push) - (Q_AW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

// ===== design/cfvg_back.sv =====
`default_nettype none
module cfvg_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  cfvg_pkg::qitem_t                 q_item,
  input  wire logic                        q_empty,
  output logic                             q_pop,
  input  wire logic [cfvg_pkg::RAD_W-1:0]  radius,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [cfvg_pkg::POS_W-1:0]       out_x_pos,
  output logic [cfvg_pkg::POS_W-1:0]       out_y_pos,
  output logic                             out_color_red,
  output logic                             out_color_green,
  output logic                             out_color_blue,
  output logic                             out_in_range
);
  import cfvg_pkg::*;

  typedef struct packed {
    logic [PROD_W-1:0] prod;
    logic [ZW-1:0]     z;
    logic [1:0]        quad;
    logic [LIM_W-1:0]  lim;
    logic              rim;
    logic              in_range;
    logic              odd;
  } pstage_t;

  typedef struct packed {
    logic [XW-1:0]    x;
    logic [XW-1:0]    y;
    logic [ZW-1:0]    z;
    logic [1:0]       quad;
    logic [LIM_W-1:0] lim;
    logic             rim;
    logic             in_range;
    logic             odd;
  } cstage_t;

  typedef struct packed {
    logic [RW-1:0]    c;
    logic [RW-1:0]    s;
    logic [LIM_W-1:0] lim;
    logic             rim;
    logic             in_range;
    logic             odd;
  } fstage_t;

  logic                   en;
  pstage_t                p_r;
  logic                   p_vld_r;
  cstage_t                cs_r [0:CORDIC_STAGES];
  logic [CORDIC_STAGES:0] c_vld_r;
  fstage_t                f_r;
  logic                   f_vld_r;
  logic                   out_valid_r;
  logic [POS_W-1:0]       x_pos_r;
  logic [POS_W-1:0]       y_pos_r;
  logic                   red_r;
  logic                   green_r;
  logic                   blue_r;
  logic                   in_range_r;

  pstage_t                p_nxt;
  cstage_t                c0_nxt;
  fstage_t                f_nxt;
  logic [LIM_W-1:0]       r256;
  logic [PROD_W-1:0]      prod_rnd;
  logic signed [XW-1:0]   cv;
  logic signed [XW-1:0]   sv;
  logic signed [XW-1:0]   fx;
  logic signed [XW-1:0]   fy;
  logic                   live;

  function automatic cstage_t rot(input cstage_t s, input logic [4:0] idx);
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic signed [ZW-1:0] zs;
    logic signed [ZW-1:0] at;
    cstage_t              o;
    xs = signed'(s.x);
    ys = signed'(s.y);
    zs = signed'(s.z);
    at = signed'(ATAN_TURNS[idx]);
    dx = ys >>> idx;
    dy = xs >>> idx;
    o = s;
    if (!zs[ZW-1]) begin
      o.x = xs - dx;
      o.y = ys + dy;
      o.z = zs - at;
    end else begin
      o.x = xs + dx;
      o.y = ys - dy;
      o.z = zs + at;
    end
    return o;
  endfunction

  function automatic logic [POS_W-1:0] clamp(input logic [RW-1:0] v,
                                             input logic [LIM_W-1:0] lim);
    logic signed [RW-1:0] vs;
    logic signed [RW-1:0] lv;
    logic signed [RW-1:0] mx;
    vs = signed'(v);
    lv = signed'(RW'(lim));
    mx = signed'(RW'(OUT_MAX));
    if (vs > lv) vs = lv;
    if (vs < -lv) vs = -lv;
    if (vs > mx) vs = mx;
    if (vs < -mx) vs = -mx;
    return POS_W'(vs);
  endfunction

  assign en    = !out_valid_r || out_ready;
  assign q_pop = en && !q_empty;

  always_comb begin
    r256 = {radius, FRAC_BITS'(0)};
    p_nxt.prod     = PROD_W'(r256) * PROD_W'(GAIN_Q32);
    p_nxt.z        = {2'b00, q_item.phase[PH_W-3:0], GUARD'(0)};
    p_nxt.quad     = q_item.phase[PH_W-1:PH_W-2];
    p_nxt.lim      = r256;
    p_nxt.rim      = q_item.rim;
    p_nxt.in_range = q_item.in_range;
    p_nxt.odd      = q_item.odd;
  end

  always_comb begin
    prod_rnd = p_r.prod + PROD_W'(1 << (GUARD-1));
    c0_nxt.x        = XW'(prod_rnd >> GUARD);
    c0_nxt.y        = '0;
    c0_nxt.z        = p_r.z;
    c0_nxt.quad     = p_r.quad;
    c0_nxt.lim      = p_r.lim;
    c0_nxt.rim      = p_r.rim;
    c0_nxt.in_range = p_r.in_range;
    c0_nxt.odd      = p_r.odd;
  end

  // Fold the quadrant back in, then round away the guard bits.
  always_comb begin
    cv = signed'(cs_r[CORDIC_STAGES].x);
    sv = signed'(cs_r[CORDIC_STAGES].y);
    case (cs_r[CORDIC_STAGES].quad)
      2'd0: begin
        fx = cv;
        fy = sv;
      end
      2'd1: begin
        fx = -sv;
        fy = cv;
      end
      2'd2: begin
        fx = -cv;
        fy = -sv;
      end
      default: begin
        fx = sv;
        fy = -cv;
      end
    endcase
    f_nxt.c        = RW'((fx + XW'(1 << (GUARD-1))) >>> GUARD);
    f_nxt.s        = RW'((fy + XW'(1 << (GUARD-1))) >>> GUARD);
    f_nxt.lim      = cs_r[CORDIC_STAGES].lim;
    f_nxt.rim      = cs_r[CORDIC_STAGES].rim;
    f_nxt.in_range = cs_r[CORDIC_STAGES].in_range;
    f_nxt.odd      = cs_r[CORDIC_STAGES].odd;
  end

  assign live = f_r.rim && f_r.in_range;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r     <= 1'b0;
      c_vld_r     <= '0;
      f_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      p_vld_r     <= q_pop;
      c_vld_r     <= {c_vld_r[CORDIC_STAGES-1:0], p_vld_r};
      f_vld_r     <= c_vld_r[CORDIC_STAGES];
      out_valid_r <= f_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r     <= p_nxt;
      cs_r[0] <= c0_nxt;
      for (int i = 0; i < CORDIC_STAGES; i++) begin
        cs_r[i+1] <= rot(cs_r[i], 5'(i));
      end
      f_r        <= f_nxt;
      x_pos_r    <= live ? clamp(f_r.c, f_r.lim) : '0;
      y_pos_r    <= live ? clamp(f_r.s, f_r.lim) : '0;
      red_r      <= f_r.in_range && !f_r.odd;
      green_r    <= f_r.in_range && f_r.odd;
      blue_r     <= f_r.in_range && !f_r.odd;
      in_range_r <= f_r.in_range;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_x_pos       = x_pos_r;
  assign out_y_pos       = y_pos_r;
  assign out_color_red   = red_r;
  assign out_color_green = green_r;
  assign out_color_blue  = blue_r;
  assign out_in_range    = in_range_r;

endmodule
`default_nettype wire
